// ----- sv/boolean_formula_lexer_core_macros.svh -----
// Assertion helpers used by the checker module.
`ifndef BOOLEAN_FORMULA_LEXER_CORE_MACROS_SVH
`define BOOLEAN_FORMULA_LEXER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BFL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfl assertion failed");

// Next-cycle implication, disabled while in reset.
`define BFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfl assertion failed");

`endif

// ----- sv/bfl_pkg.sv -----
`default_nettype none

package bfl_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_LT      = 3'd2,
      MODE_LTDASH  = 3'd3,
      MODE_DASH    = 3'd4,
      MODE_NAME    = 3'd5
   } mode_type;

   typedef enum logic [3:0] {
      KIND_END      = 4'd0,
      KIND_IFF      = 4'd1,
      KIND_IMPLIES  = 4'd2,
      KIND_AND      = 4'd3,
      KIND_OR       = 4'd4,
      KIND_NOT      = 4'd5,
      KIND_LPAREN   = 4'd6,
      KIND_RPAREN   = 4'd7,
      KIND_NAMECHAR = 4'd8,
      KIND_NAMEEND  = 4'd9,
      KIND_ERROR    = 4'd10
   } kind_type;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LT      = 8'h3C;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_AT      = 8'h40;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK  = 8'h5D;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_BAR     = 8'h7C;
   localparam logic [7:0] CHAR_TILDE   = 8'h7E;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_BITS   = 2;
   localparam int unsigned CNT_BITS   = 3;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  ch;
      logic [15:0] line;
      logic [15:0] column;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic     emit;
      logic     set_tok;
      kind_type kind;
      mode_type mode;
   } start_type;

   function automatic logic is_name_char(input logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             c == CHAR_DASH || c == CHAR_UNDER || c == CHAR_DOT ||
             c == CHAR_LBRACK || c == CHAR_RBRACK ||
             c == CHAR_DOLLAR || c == CHAR_AT;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // Decode a character seen in idle mode, or one that closes a name, as a possible token start.
   function automatic start_type scan_start(input logic [7:0] c);
      start_type s;
      s.emit    = 1'b1;
      s.set_tok = 1'b1;
      s.kind    = KIND_ERROR;
      s.mode    = MODE_IDLE;
      if (is_space(c)) begin
         s.emit    = 1'b0;
         s.set_tok = 1'b0;
      end else if (c == CHAR_PERCENT) begin
         s.emit    = 1'b0;
         s.set_tok = 1'b0;
         s.mode    = MODE_COMMENT;
      end else begin
         case (c)
            CHAR_NUL:    s.kind = KIND_END;
            CHAR_LT: begin
               s.emit = 1'b0;
               s.mode = MODE_LT;
            end
            CHAR_DASH: begin
               s.emit = 1'b0;
               s.mode = MODE_DASH;
            end
            CHAR_AMP:    s.kind = KIND_AND;
            CHAR_BAR:    s.kind = KIND_OR;
            CHAR_BANG,
            CHAR_TILDE:  s.kind = KIND_NOT;
            CHAR_LPAREN: s.kind = KIND_LPAREN;
            CHAR_RPAREN: s.kind = KIND_RPAREN;
            default: begin
               if (is_name_char(c)) begin
                  s.kind = KIND_NAMECHAR;
                  s.mode = MODE_NAME;
               end
            end
         endcase
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- sv/boolean_formula_lexer_core.sv -----
// Boolean formula lexer core.
// Request channel: one character byte per request on req_char_in (zero marks
// end of expression), accepted when req_valid and req_ready are both high.
// Response channel: one token per response; a character yields zero, one or
// two tokens, and rsp_last_result flags the last token of a character.
// Each token carries its zero-based start line and one-based start column,
// both saturating.
// Tokens enter a registered output queue when their character is accepted.
// Throughput: one character per cycle while each character yields at most
// one token and rsp_ready stays high; a character that closes a name and
// starts a token yields two tokens. The rate is set by the single response
// port draining a four-entry output queue.
// req_ready is high while the queue holds two tokens or fewer, so a stalled
// receiver backs up the request side after two or three token-making requests.
// Reset clears the scanner to idle, the position counters to zero and empties
// the queue.
`default_nettype none

module boolean_formula_lexer_core #(
   parameter int unsigned POS_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_char_in,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [3:0]  rsp_token_kind,
   output      logic [7:0]  rsp_name_char,
   output      logic [15:0] rsp_start_line,
   output      logic [15:0] rsp_start_column,
   output      logic        rsp_last_result
);
   import bfl_pkg::*;

   localparam int unsigned EXT_BITS = (POS_BITS > 16) ? POS_BITS : 16;

   mode_type              mode_ff, mode_in;
   logic                  dash_ff, dash_in;
   logic [POS_BITS-1:0]   cur_line_ff, cur_line_in;
   logic [POS_BITS-1:0]   cur_col_ff, cur_col_in;
   logic [POS_BITS-1:0]   tok_line_ff, tok_line_in;
   logic [POS_BITS-1:0]   tok_col_ff, tok_col_in;

   rsp_type               fifo_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   logic                  accept;
   logic                  pop;
   logic [7:0]            c;
   start_type             st;
   logic                  a_emit, b_emit;
   kind_type              a_kind, b_kind;
   logic [POS_BITS-1:0]   a_line, a_col;
   rsp_type               res_a, res_b;
   logic [PTR_BITS-1:0]   wr_ptr_b;
   logic [CNT_BITS-1:0]   push_cnt;

   function automatic logic [15:0] clip16(input logic [POS_BITS-1:0] v);
      logic [EXT_BITS-1:0] ext;
      ext = EXT_BITS'(v);
      return (ext > EXT_BITS'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
   endfunction

   function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
      return (&v) ? v : v + POS_BITS'(1);
   endfunction

   assign c         = req_char_in;
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff <= CNT_BITS'(FIFO_DEPTH - 2));
   assign st        = scan_start(c);

   always_comb begin
      // position moves before the character is scanned
      if (c == CHAR_LF) begin
         cur_line_in = sat_inc(cur_line_ff);
         cur_col_in  = '0;
      end else begin
         cur_line_in = cur_line_ff;
         cur_col_in  = sat_inc(cur_col_ff);
      end

      mode_in     = mode_ff;
      dash_in     = dash_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      a_emit      = 1'b0;
      a_kind      = KIND_ERROR;
      a_line      = tok_line_ff;
      a_col       = tok_col_ff;
      b_emit      = 1'b0;
      b_kind      = st.kind;

      case (mode_ff)
         MODE_COMMENT: begin
            if (c == CHAR_LF) begin
               mode_in = MODE_IDLE;
            end else if (c == CHAR_NUL) begin
               mode_in     = MODE_IDLE;
               tok_line_in = cur_line_in;
               tok_col_in  = cur_col_in;
               a_emit      = 1'b1;
               a_kind      = KIND_END;
               a_line      = cur_line_in;
               a_col       = cur_col_in;
            end
         end
         MODE_LT: begin
            mode_in = (c == CHAR_DASH) ? MODE_LTDASH : MODE_IDLE;
            a_emit  = (c != CHAR_DASH);
         end
         MODE_LTDASH: begin
            mode_in = MODE_IDLE;
            a_emit  = 1'b1;
            a_kind  = (c == CHAR_GT) ? KIND_IFF : KIND_ERROR;
         end
         MODE_DASH: begin
            mode_in = MODE_IDLE;
            a_emit  = 1'b1;
            a_kind  = (c == CHAR_GT) ? KIND_IMPLIES : KIND_ERROR;
         end
         MODE_NAME: begin
            a_emit = 1'b1;
            if (is_name_char(c)) begin
               dash_in = (c == CHAR_DASH);
               a_kind  = KIND_NAMECHAR;
            end else begin
               // close the name, then rescan the character as a new start
               a_kind  = dash_ff ? KIND_ERROR : KIND_NAMEEND;
               dash_in = 1'b0;
               mode_in = st.mode;
               b_emit  = st.emit;
               if (st.set_tok) begin
                  tok_line_in = cur_line_in;
                  tok_col_in  = cur_col_in;
               end
            end
         end
         default: begin
            mode_in = st.mode;
            a_emit  = st.emit;
            a_kind  = st.kind;
            if (st.set_tok) begin
               tok_line_in = cur_line_in;
               tok_col_in  = cur_col_in;
               a_line      = cur_line_in;
               a_col       = cur_col_in;
            end
            if (st.mode == MODE_NAME) begin
               dash_in = 1'b0;
            end
         end
      endcase

      res_a.kind   = a_kind;
      res_a.ch     = (a_kind == KIND_NAMECHAR) ? c : 8'h00;
      res_a.line   = clip16(a_line);
      res_a.column = clip16(a_col);
      res_a.last   = !b_emit;

      res_b.kind   = b_kind;
      res_b.ch     = (b_kind == KIND_NAMECHAR) ? c : 8'h00;
      res_b.line   = clip16(cur_line_in);
      res_b.column = clip16(cur_col_in);
      res_b.last   = 1'b1;
   end

   always_comb begin
      push_cnt  = accept ? (CNT_BITS'(a_emit) + CNT_BITS'(b_emit)) : '0;
      wr_ptr_b  = wr_ptr_ff + PTR_BITS'(1);
      wr_ptr_in = wr_ptr_ff + push_cnt[PTR_BITS-1:0];
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in  = count_ff + push_cnt - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         dash_ff     <= 1'b0;
         cur_line_ff <= '0;
         cur_col_ff  <= '0;
         tok_line_ff <= '0;
         tok_col_ff  <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (accept) begin
            mode_ff     <= mode_in;
            dash_ff     <= dash_in;
            cur_line_ff <= cur_line_in;
            cur_col_ff  <= cur_col_in;
            tok_line_ff <= tok_line_in;
            tok_col_ff  <= tok_col_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload needs no reset
   always_ff @(posedge clock) begin
      if (accept && a_emit) begin
         fifo_ff[wr_ptr_ff] <= res_a;
      end
      if (accept && b_emit) begin
         fifo_ff[wr_ptr_b] <= res_b;
      end
   end

   assign rsp_valid        = (count_ff != '0);
   assign rsp_token_kind   = fifo_ff[rd_ptr_ff].kind;
   assign rsp_name_char    = fifo_ff[rd_ptr_ff].ch;
   assign rsp_start_line   = fifo_ff[rd_ptr_ff].line;
   assign rsp_start_column = fifo_ff[rd_ptr_ff].column;
   assign rsp_last_result  = fifo_ff[rd_ptr_ff].last;

endmodule

`default_nettype wire

// ----- sv/bfl_checker.sv -----
`default_nettype none

module bfl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_char_in,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_token_kind,
   input wire logic [7:0]  rsp_name_char,
   input wire logic [15:0] rsp_start_line,
   input wire logic [15:0] rsp_start_column,
   input wire logic        rsp_last_result
);
   import bfl_pkg::*;

   `include "boolean_formula_lexer_core_macros.svh"

   // hold a stalled response
   `BFL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_token_kind) && $stable(rsp_name_char) && $stable(rsp_start_line) && $stable(rsp_start_column) && $stable(rsp_last_result))

   // an end-of-expression request always yields a token
   `BFL_ASSERT_NEXT(a_nul_yields, clock, reset, req_valid && req_ready && req_char_in == CHAR_NUL, rsp_valid)

   `BFL_ASSERT_IMPLY(a_char_only_on_name, clock, reset, rsp_valid && rsp_token_kind != KIND_NAMECHAR, rsp_name_char == 8'h00)

   // a name character is always the final token of its request
   `BFL_ASSERT_IMPLY(a_namechar_last, clock, reset, rsp_valid && rsp_token_kind == KIND_NAMECHAR, rsp_last_result)

endmodule

bind boolean_formula_lexer_core bfl_checker u_bfl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_char_in      (req_char_in),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_name_char    (rsp_name_char),
   .rsp_start_line   (rsp_start_line),
   .rsp_start_column (rsp_start_column),
   .rsp_last_result  (rsp_last_result)
);

`default_nettype wire
